[rtl/rca_pkg.sv]
// Shared types and constants for the reference-counted block allocator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rca_pkg;

    // Default pool geometry
    localparam int POOL_BLOCKS_DEF = 1024;
    localparam int COUNT_BITS_DEF  = 8;

    // Fixed payload widths
    localparam int CMD_W    = 2;
    localparam int BLOCK_W  = 16;
    localparam int STATUS_W = 3;
    localparam int GRANT_W  = 10;
    localparam int FREE_W   = 11;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_ADDREF  = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_EMPTY    = 3'd1,
        STS_RANGE    = 3'd2,
        STS_FREE     = 3'd3,
        STS_DOUBLE   = 3'd4,
        STS_OVERFLOW = 3'd5
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

`default_nettype wire

[rtl/rca_if.sv]
// Valid/ready channel interfaces for the allocator: request and response words.
// Depends on rca_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface rca_req_if
    import rca_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [BLOCK_W-1:0] block;

    modport source (output valid, output cmd, output block, input ready);
    modport sink   (input valid, input cmd, input block, output ready);
endinterface

interface rca_rsp_if
    import rca_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  granted_block;
    logic                returned_to_pool;
    logic [FREE_W-1:0]   free_blocks;

    modport source (output valid, output status, output granted_block,
                    output returned_to_pool, output free_blocks, input ready);
    modport sink   (input valid, input status, input granted_block,
                    input returned_to_pool, input free_blocks, output ready);
endinterface

`default_nettype wire

[rtl/refcounted_block_allocator.sv]
// Reference-counted block allocator: free-id stack and count memory with a sequencer.
// Depends on rca_pkg and the rca_req_if / rca_rsp_if channel interfaces.
//
// A pool of POOL_BLOCKS blocks, each with a COUNT_BITS reference count, and a LIFO
// stack of free ids that hands out blocks 0, 1, 2, ... first after reset. Each
// request word yields exactly one response word. After reset the block runs a
// clearing pass that presets the stack memory and zeroes the count memory;
// req.ready stays low until it ends. Afterwards the accept cycle of a request
// issues the synchronous reads of the stack top and of the addressed count, and
// the S_EXEC state that follows modifies and writes both memories back and loads
// the response register. A stalled response holds S_EXEC until the response
// register frees up. A response waiting at the output does not block the next
// request from being accepted.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_block_allocator
    import rca_pkg::*;
#(
    parameter int POOL_BLOCKS = POOL_BLOCKS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rca_req_if.sink    req,
    rca_rsp_if.source  rsp
);

    localparam int IDX_W   = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int DEPTH_W = $clog2(POOL_BLOCKS + 1);

    // Memories
    logic [IDX_W-1:0]      stack_mem [0:POOL_BLOCKS-1];
    logic [COUNT_BITS-1:0] count_mem [0:POOL_BLOCKS-1];

    // Control state
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_idx_reg, clr_idx_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic                 out_valid_reg, out_valid_next;

    // Captured request and read data
    logic [CMD_W-1:0]          cmd_reg;
    logic signed [BLOCK_W-1:0] blk_reg;
    logic [IDX_W-1:0]          stk_q_reg;
    logic [COUNT_BITS-1:0]     cnt_q_reg;

    // Response payload registers
    status_t              status_reg;
    logic [GRANT_W-1:0]   granted_reg;
    logic                 returned_reg;
    logic [FREE_W-1:0]    free_reg;

    // Combinational signals
    logic                  accept;
    logic                  exec_go;
    logic [DEPTH_W-1:0]    depth_m1;
    logic [IDX_W-1:0]      stk_raddr;
    logic [IDX_W-1:0]      cnt_raddr;
    logic                  stk_we;
    logic [IDX_W-1:0]      stk_waddr;
    logic [IDX_W-1:0]      stk_wdata;
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [BLOCK_W-1:0]    raw;
    logic                  in_range;
    logic [IDX_W-1:0]      blk_idx;
    status_t               status_c;
    logic [IDX_W-1:0]      granted_c;
    logic                  returned_c;
    logic [15:0]           grant_ext;
    logic [15:0]           depth_ext;

    assign accept    = req.valid && req.ready;
    assign exec_go   = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign depth_m1  = depth_reg - 1'b1;
    assign stk_raddr = depth_m1[IDX_W-1:0];
    assign cnt_raddr = req.block[IDX_W-1:0];
    assign raw       = blk_reg;
    assign in_range  = !raw[BLOCK_W-1] && ({1'b0, raw} < 17'(POOL_BLOCKS));
    assign blk_idx   = raw[IDX_W-1:0];
    assign grant_ext = 16'(granted_c);
    assign depth_ext = 16'(depth_next);

    // State register and control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            depth_reg     <= DEPTH_W'(POOL_BLOCKS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state, memory write-back and response
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        depth_next     = depth_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        req.ready      = 1'b0;
        stk_we         = 1'b0;
        stk_waddr      = depth_reg[IDX_W-1:0];
        stk_wdata      = blk_idx;
        cnt_we         = 1'b0;
        cnt_waddr      = blk_idx;
        cnt_wdata      = cnt_q_reg;
        status_c       = STS_OK;
        granted_c      = '0;
        returned_c     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Preset stack entry i to the pool size minus one minus i, zero count entry i
                stk_we    = 1'b1;
                stk_waddr = clr_idx_reg;
                stk_wdata = IDX_W'(POOL_BLOCKS - 1) - clr_idx_reg;
                cnt_we    = 1'b1;
                cnt_waddr = clr_idx_reg;
                cnt_wdata = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(POOL_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (depth_reg == '0)
                        begin
                            status_c = STS_EMPTY;
                        end
                        else
                        begin
                            depth_next = depth_m1;
                            granted_c  = stk_q_reg;
                            cnt_we     = 1'b1;
                            cnt_waddr  = stk_q_reg;
                            cnt_wdata  = COUNT_BITS'(1);
                        end
                    end
                    CMD_ADDREF:
                    begin
                        if (!in_range)
                        begin
                            status_c = STS_RANGE;
                        end
                        else if (cnt_q_reg == '0)
                        begin
                            status_c = STS_FREE;
                        end
                        else if (&cnt_q_reg)
                        begin
                            status_c = STS_OVERFLOW;
                        end
                        else
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt_q_reg + 1'b1;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (!in_range)
                        begin
                            status_c = STS_RANGE;
                        end
                        else if (cnt_q_reg == '0)
                        begin
                            status_c = STS_DOUBLE;
                        end
                        else
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt_q_reg - 1'b1;
                            if (cnt_q_reg == COUNT_BITS'(1))
                            begin
                                returned_c = 1'b1;
                                // Push back onto the free stack
                                if (depth_reg < DEPTH_W'(POOL_BLOCKS))
                                begin
                                    stk_we     = 1'b1;
                                    depth_next = depth_reg + 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        status_c = STS_OK;
                    end
                endcase

                // Hold everything until the response register frees up
                if (exec_go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    stk_we     = 1'b0;
                    cnt_we     = 1'b0;
                    depth_next = depth_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Capture the request word on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.cmd;
            blk_reg <= req.block;
        end
    end

    // Load the response word
    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            status_reg   <= status_c;
            granted_reg  <= grant_ext[GRANT_W-1:0];
            returned_reg <= returned_c;
            free_reg     <= depth_ext[FREE_W-1:0];
        end
    end

    // Free stack memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (accept)
        begin
            stk_q_reg <= stack_mem[stk_raddr];
        end
    end

    // Reference count memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (accept)
        begin
            cnt_q_reg <= count_mem[cnt_raddr];
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.granted_block    = granted_reg;
    assign rsp.returned_to_pool = returned_reg;
    assign rsp.free_blocks      = free_reg;

    // Stack depth never exceeds the pool size
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(POOL_BLOCKS))
        else $error("free stack depth above pool size");

    // An accepted word puts the sequencer into S_EXEC in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted word not executed");

    // A granted block takes exactly one entry off the stack
    a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && cmd_reg == CMD_ALLOC && status_c == STS_OK)
        |=> depth_reg == $past(depth_m1))
        else $error("allocate did not pop the stack");

    // A block goes back to the pool only on a successful release
    a_return_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.returned_to_pool) |-> rsp.status == STS_OK)
        else $error("block returned on a failed operation");

    // A failed operation grants nothing
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STS_OK) |-> rsp.granted_block == '0)
        else $error("block granted on a failed operation");

endmodule

`default_nettype wire

[sim/rca_checker.sv]
// Scoreboard for the reference-counted block allocator: tracks the free-id stack and
// per-block counts, predicts each response word and compares it with the block's output.
// Depends on rca_pkg and the rca_req_if / rca_rsp_if channel interfaces.
`timescale 1ns / 1ps

module rca_checker
    import rca_pkg::*;
#(
    parameter int POOL_BLOCKS = POOL_BLOCKS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rca_req_if         req,
    rca_rsp_if         rsp,
    output int         mismatches,
    output int         pending,
    output int         compared,
    output logic [7:0] status_seen
);

    typedef struct packed {
        status_t             status;
        logic [GRANT_W-1:0]  granted;
        logic                returned;
        logic [FREE_W-1:0]   free_count;
    } alloc_word_t;

    // Shadow of the pool: free-id stack, its depth and the per-block holder counts
    logic [GRANT_W-1:0]    free_ids [POOL_BLOCKS];
    logic [COUNT_BITS-1:0] holders  [POOL_BLOCKS];
    int                    depth;

    alloc_word_t           awaited_words [$];

    // Apply one request to the shadow pool and return the response it should produce
    function automatic alloc_word_t serve_command(logic [CMD_W-1:0] op,
                                                  logic signed [BLOCK_W-1:0] id);
        alloc_word_t w;
        int          idx;
        w = '{status: STS_OK, granted: '0, returned: 1'b0, free_count: '0};
        idx = int'(id);
        case (op)
            CMD_ALLOC:
            begin
                if (depth == 0)
                begin
                    w.status = STS_EMPTY;
                end
                else
                begin
                    depth--;
                    w.granted = free_ids[depth];
                    holders[free_ids[depth]] = COUNT_BITS'(1);
                end
            end
            CMD_ADDREF, CMD_RELEASE:
            begin
                if (idx < 0 || idx >= POOL_BLOCKS)
                begin
                    w.status = STS_RANGE;
                end
                else if (op == CMD_ADDREF)
                begin
                    // saturate at the counter maximum
                    if (holders[idx] == '0)
                        w.status = STS_FREE;
                    else if (holders[idx] == '1)
                        w.status = STS_OVERFLOW;
                    else
                        holders[idx] = holders[idx] + 1'b1;
                end
                else
                begin
                    if (holders[idx] == '0)
                    begin
                        w.status = STS_DOUBLE;
                    end
                    else
                    begin
                        holders[idx] = holders[idx] - 1'b1;
                        // last holder gone: push the id back on the stack
                        if (holders[idx] == '0)
                        begin
                            w.returned = 1'b1;
                            if (depth < POOL_BLOCKS)
                            begin
                                free_ids[depth] = GRANT_W'(idx);
                                depth++;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        w.free_count = FREE_W'(depth);
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_word_t want;
        alloc_word_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_BLOCKS; i++)
            begin
                free_ids[i] = GRANT_W'(POOL_BLOCKS - 1 - i);
                holders[i]  = '0;
            end
            depth = POOL_BLOCKS;
            awaited_words.delete();
            mismatches  = 0;
            pending     = 0;
            compared    = 0;
            status_seen = '0;
        end
        else
        begin
            // predict on every accepted request word
            if (req.valid && req.ready)
                awaited_words.insert(awaited_words.size(), serve_command(req.cmd, req.block));

            // compare every accepted response word with the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                got.status     = status_t'(rsp.status);
                got.granted    = rsp.granted_block;
                got.returned   = rsp.returned_to_pool;
                got.free_count = rsp.free_blocks;
                status_seen[rsp.status] = 1'b1;
                if (awaited_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%t: response word with none outstanding: ",
                                  "status %0d granted %0d returned %0d free %0d"},
                                 $time, got.status, got.granted, got.returned,
                                 got.free_count);
                end
                else
                begin
                    want = awaited_words.pop_front();
                    compared++;
                    if (got.status !== want.status || got.granted !== want.granted ||
                        got.returned !== want.returned || got.free_count !== want.free_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%t: response %0d mismatch: expected status %0d ",
                                      "granted %0d returned %0d free %0d, got status %0d ",
                                      "granted %0d returned %0d free %0d"},
                                     $time, compared, want.status, want.granted,
                                     want.returned, want.free_count, got.status,
                                     got.granted, got.returned, got.free_count);
                    end
                end
            end
            pending = awaited_words.size();
        end
    end

endmodule

[sim/tb.sv]
// Top of the allocator testbench: clock, reset, request stimulus, response back-pressure,
// watchdog and verdict. Depends on rca_pkg, the channel interfaces, the allocator
// and the rca_checker scoreboard.
`timescale 1ns / 1ps

module tb
    import rca_pkg::*;
();

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int POOL_SIZE      = POOL_BLOCKS_DEF;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 20;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rca_req_if req ();
    rca_rsp_if rsp ();

    int         mismatches;
    int         pending;
    int         compared;
    logic [7:0] status_seen;

    bit hold_output = 1'b0;
    bit steady      = 1'b0;
    int issued      = 0;
    int idle_cycles = 0;

    refcounted_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    rca_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .pending     (pending),
        .compared    (compared),
        .status_seen (status_seen)
    );

    always #6 clk = ~clk;

    // Offer one request word and hold it until accepted
    task automatic send_word(input logic [CMD_W-1:0] op, input logic signed [BLOCK_W-1:0] id);
        @(negedge clk);
        req.valid <= 1'b1;
        req.cmd   <= op;
        req.block <= id;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        issued++;
    endtask

    // Drop valid for a random burst now and then
    task automatic maybe_pause();
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 14))
            begin
                @(negedge clk);
                req.valid <= 1'b0;
            end
        end
    endtask

    // Pick a block id: mostly inside a window at the bottom of the pool, sometimes anywhere or just past the pool
    function automatic logic signed [BLOCK_W-1:0] pick_id(int window);
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            pick_id = BLOCK_W'($urandom());
        else if (r == 2)
            pick_id = BLOCK_W'(POOL_SIZE + int'($urandom_range(0, 31)));
        else
            pick_id = BLOCK_W'($urandom_range(0, window - 1));
    endfunction

    task automatic random_word(int window);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            send_word(CMD_ALLOC, BLOCK_W'($urandom()));
        else if (r < 65)
            send_word(CMD_ADDREF, pick_id(window));
        else if (r < 98)
            send_word(CMD_RELEASE, pick_id(window));
        else
            send_word(CMD_UNUSED, BLOCK_W'($urandom()));
        maybe_pause();
    endtask

    // Response back-pressure: random stall bursts, one long hold on request, none at the end
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD - 1)
                    @(negedge clk);
                hold_output = 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1)
                    @(negedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d responses outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.cmd   = CMD_ALLOC;
        req.block = '0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: grants in order, release to zero, double free, free block, id extremes
        send_word(CMD_ALLOC, 16'sh7fff);
        send_word(CMD_ALLOC, 16'sh8000);
        send_word(CMD_ADDREF, 16'sd0);
        send_word(CMD_RELEASE, 16'sd0);
        send_word(CMD_RELEASE, 16'sd0);
        send_word(CMD_RELEASE, 16'sd0);
        send_word(CMD_ADDREF, 16'sd0);
        send_word(CMD_ADDREF, 16'sh8000);
        send_word(CMD_RELEASE, 16'sh7fff);
        send_word(CMD_ADDREF, 16'(POOL_SIZE));
        send_word(CMD_ADDREF, 16'(POOL_SIZE - 1));
        send_word(CMD_RELEASE, 16'(POOL_SIZE - 1));
        send_word(CMD_RELEASE, 16'shffff);
        send_word(CMD_UNUSED, 16'sh5555);
        send_word(CMD_UNUSED, 16'shaaaa);
        send_word(CMD_ALLOC, 16'sd0);
        send_word(CMD_RELEASE, 16'sd1);
        send_word(CMD_RELEASE, 16'sd0);
        send_word(CMD_ALLOC, 16'sd0);
        send_word(CMD_ALLOC, 16'sd0);

        // Mixed traffic on low ids while the output is held off for a long stretch
        hold_output = 1'b1;
        repeat (200)
            random_word(32);

        // Pause the sender until every response is back
        @(negedge clk);
        req.valid <= 1'b0;
        wait (pending == 0);

        repeat (150)
            random_word(128);

        // Drain the pool completely and knock on it once empty
        repeat (POOL_SIZE + 16)
        begin
            send_word(CMD_ALLOC, BLOCK_W'($urandom()));
            maybe_pause();
        end

        // Drive one held block into counter saturation, then back down a little
        repeat (260)
        begin
            send_word(CMD_ADDREF, 16'sd5);
            maybe_pause();
        end
        repeat (40)
        begin
            send_word(CMD_RELEASE, 16'sd5);
            maybe_pause();
        end

        repeat (40)
            random_word(POOL_SIZE);

        // Final stretch with no idling on either side
        steady = 1'b1;
        repeat (100)
            random_word(POOL_SIZE);

        @(negedge clk);
        req.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Issued %0d request words and compared %0d responses, through a full drain,",
                 issued, compared);
        $display("counter saturation and long output stalls; status codes seen (bit per code): %b",
                 status_seen);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
